// ===== sv/spdc_pkg.sv =====
// Shared types, codes and the CRC-8 byte step for the serial packet deframer.
package spdc_pkg;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_INFO    = 2'd1;
   localparam logic [1:0] PH_MESSAGE = 2'd2;

   localparam logic [2:0] EV_CONSUMED  = 3'd0;
   localparam logic [2:0] EV_HDR_OK    = 3'd1;
   localparam logic [2:0] EV_HDR_BAD   = 3'd2;
   localparam logic [2:0] EV_MSG_BYTE  = 3'd3;
   localparam logic [2:0] EV_LAST_OK   = 3'd4;
   localparam logic [2:0] EV_LAST_BAD  = 3'd5;
   localparam logic [2:0] EV_EMPTY_MSG = 3'd6;

   localparam logic [7:0] CRC_POLY        = 8'h07;
   localparam logic [7:0] CRC_INIT        = 8'h00;
   localparam logic [2:0] OP_MAX          = 3'd4;
   localparam logic [3:0] STATUS_MAX      = 4'd1;
   localparam logic [7:0] MAX_CHANNEL_RST = 8'd3;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] channel;
      logic [2:0] op_code;
      logic [3:0] status_code;
      logic       has_payload;
      logic [7:0] payload_size;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       crc_ok;
   } result_type;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/spdc_parser.sv =====
// Packet parse state, header check, CRC-8 update and result formation.
module spdc_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   output spdc_pkg::result_type   result
);
   import spdc_pkg::*;

   logic [7:0] max_channel_ff;
   logic [1:0] phase_ff,        phase_in;
   logic [7:0] byte_count_ff,   byte_count_in;
   logic [7:0] held_byte_ff,    held_byte_in;
   logic [7:0] hdr_channel_ff,  hdr_channel_in;
   logic [7:0] hdr_flags_ff,    hdr_flags_in;
   logic [7:0] frame_crc_ff,    frame_crc_in;
   logic [7:0] msg_size_ff,     msg_size_in;
   logic [7:0] running_crc_ff,  running_crc_in;
   logic [7:0] crc_next;
   logic       hdr_valid;
   logic       last_byte;

   assign crc_next  = crc8_step(running_crc_ff, rx_byte);
   assign last_byte = ({1'b0, byte_count_ff} + 9'd1) >= {1'b0, msg_size_ff};
   assign hdr_valid = (held_byte_ff <= max_channel_ff) && (rx_byte[2:0] <= OP_MAX)
                      && (rx_byte[6:3] <= STATUS_MAX);

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      held_byte_in    = held_byte_ff;
      hdr_channel_in  = hdr_channel_ff;
      hdr_flags_in    = hdr_flags_ff;
      frame_crc_in    = frame_crc_ff;
      msg_size_in     = msg_size_ff;
      running_crc_in  = running_crc_ff;
      result          = '0;
      unique case (phase_ff)
         PH_INFO: begin
            if (byte_count_ff == 8'd0) begin
               held_byte_in  = rx_byte;
               byte_count_in = 8'd1;
            end else begin
               frame_crc_in    = held_byte_ff;
               msg_size_in     = rx_byte;
               byte_count_in   = 8'd0;
               running_crc_in  = CRC_INIT;
               if (rx_byte == 8'd0) begin
                  phase_in           = PH_HEADER;
                  result.event_res   = EV_EMPTY_MSG;
                  result.channel     = hdr_channel_ff;
                  result.op_code     = hdr_flags_ff[2:0];
                  result.status_code = hdr_flags_ff[6:3];
                  result.has_payload = hdr_flags_ff[7];
                  result.crc_ok      = (held_byte_ff == CRC_INIT);
               end else begin
                  phase_in = PH_MESSAGE;
               end
            end
         end
         PH_MESSAGE: begin
            running_crc_in       = crc_next;
            result.channel       = hdr_channel_ff;
            result.op_code       = hdr_flags_ff[2:0];
            result.status_code   = hdr_flags_ff[6:3];
            result.has_payload   = hdr_flags_ff[7];
            result.payload_size  = msg_size_ff;
            result.payload_byte  = rx_byte;
            result.payload_index = byte_count_ff;
            if (last_byte) begin
               result.crc_ok    = (crc_next == frame_crc_ff);
               result.event_res = (crc_next == frame_crc_ff) ? EV_LAST_OK : EV_LAST_BAD;
               phase_in         = PH_HEADER;
               byte_count_in    = 8'd0;
            end else begin
               result.event_res = EV_MSG_BYTE;
               byte_count_in    = byte_count_ff + 8'd1;
            end
         end
         default: begin
            phase_in = PH_HEADER;
            if (byte_count_ff == 8'd0) begin
               held_byte_in  = rx_byte;
               byte_count_in = 8'd1;
            end else begin
               hdr_channel_in = held_byte_ff;
               hdr_flags_in   = rx_byte;
               byte_count_in  = 8'd0;
               if (!hdr_valid) begin
                  result.event_res   = EV_HDR_BAD;
                  result.channel     = held_byte_ff;
                  result.op_code     = rx_byte[2:0];
                  result.status_code = rx_byte[6:3];
                  result.has_payload = rx_byte[7];
               end else if (rx_byte[7]) begin
                  phase_in = PH_INFO;
               end else begin
                  result.event_res   = EV_HDR_OK;
                  result.channel     = held_byte_ff;
                  result.op_code     = rx_byte[2:0];
                  result.status_code = rx_byte[6:3];
                  result.has_payload = rx_byte[7];
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_channel_ff  <= MAX_CHANNEL_RST;
         phase_ff        <= PH_HEADER;
         byte_count_ff   <= 8'd0;
         held_byte_ff    <= 8'd0;
         hdr_channel_ff  <= 8'd0;
         hdr_flags_ff    <= 8'd0;
         frame_crc_ff    <= 8'd0;
         msg_size_ff     <= 8'd0;
         running_crc_ff  <= CRC_INIT;
      end else begin
         if (csr_wr_en) begin
            max_channel_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff        <= phase_in;
            byte_count_ff   <= byte_count_in;
            held_byte_ff    <= held_byte_in;
            hdr_channel_ff  <= hdr_channel_in;
            hdr_flags_ff    <= hdr_flags_in;
            frame_crc_ff    <= frame_crc_in;
            msg_size_ff     <= msg_size_in;
            running_crc_ff  <= running_crc_in;
         end
      end
   end

endmodule

// ===== sv/spdc_outbuf.sv =====
// Result register with a skid entry so a new transaction is taken while a result waits.
module spdc_outbuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  spdc_pkg::result_type   in_data,
   input  logic                   out_stall,
   output logic                   out_valid,
   output spdc_pkg::result_type   out_data,
   output logic                   full
);
   import spdc_pkg::*;

   logic       out_valid_ff,  out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff,   out_data_in;
   result_type skid_data_ff,  skid_data_in;
   logic       out_taken;

   assign out_taken = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_taken) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_taken) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

// ===== sv/serial_packet_deframer_crc8_core.sv =====
// Serial packet deframer with CRC-8 message check, top level.
// Takes one received byte per cycle while req_stall is low and returns exactly
// one result per byte from a registered output, valid the cycle after acceptance
// unless an earlier result still waits. The header check, the parse state update
// and the unrolled 8-bit CRC-8 step (poly 0x07, init 0, MSB first) all complete in
// the cycle a byte is taken. A two-entry output buffer keeps the input open while
// one result waits; req_stall rises only when both entries are full. The user must
// write max_channel (csr_wr_en/csr_wr_data) only while idle; the core never checks.
module serial_packet_deframer_crc8_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_channel,
   output logic [2:0] rsp_op_code,
   output logic [3:0] rsp_status_code,
   output logic       rsp_has_payload,
   output logic [7:0] rsp_payload_size,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic       rsp_crc_ok,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import spdc_pkg::*;

   logic       req_accept;
   logic       buf_full;
   result_type parse_result;
   result_type rsp_data;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !buf_full;

   spdc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (parse_result)
   );

   spdc_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (parse_result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (buf_full)
   );

   assign rsp_event_res     = rsp_data.event_res;
   assign rsp_channel       = rsp_data.channel;
   assign rsp_op_code       = rsp_data.op_code;
   assign rsp_status_code   = rsp_data.status_code;
   assign rsp_has_payload   = rsp_data.has_payload;
   assign rsp_payload_size  = rsp_data.payload_size;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_payload_index = rsp_data.payload_index;
   assign rsp_crc_ok        = rsp_data.crc_ok;

`ifndef NO_ASSERTIONS
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted transaction left no result");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_MSG_BYTE || rsp_event_res == EV_LAST_OK
                    || rsp_event_res == EV_LAST_BAD) |-> rsp_payload_index < rsp_payload_size)
      else $error("message byte index beyond message size");

   a_empty_size_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_EMPTY_MSG |-> rsp_payload_size == 8'd0)
      else $error("empty message result with nonzero size");
`endif

endmodule
